[sv/dac_spi_command_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// dac_spi_command_sequencer_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef DAC_SPI_COMMAND_SEQUENCER_DEFINES_SVH
`define DAC_SPI_COMMAND_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define DSC_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dsc check failed");

// next-cycle implication, sampled on clock, off during reset
`define DSC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dsc check failed");

`endif

[sv/dsc_pkg.sv]
// ----------------------------------------------------------------------------
// dsc_pkg
// types, frame constants and command expansion for the spi dac sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_INIT    = 3'd1,
      REQ_DISABLE = 3'd2,
      REQ_CURRENT = 3'd3,
      REQ_VOLTAGE = 3'd4,
      REQ_STATUS  = 3'd5,
      REQ_RESET   = 3'd6,
      REQ_NOP     = 3'd7
   } req_code_type;

   // dac register addresses
   localparam logic [7:0] ADDR_NOP     = 8'h00;
   localparam logic [7:0] ADDR_DATA    = 8'h01;
   localparam logic [7:0] ADDR_READ    = 8'h02;
   localparam logic [7:0] ADDR_CONTROL = 8'h55;
   localparam logic [7:0] ADDR_RESET   = 8'h56;
   localparam logic [7:0] ADDR_CONFIG  = 8'h57;

   // data words
   localparam logic [15:0] DATA_ZERO     = 16'h0000;
   localparam logic [15:0] RESET_KEY     = 16'h0001;
   localparam logic [15:0] RANGE_VOLTAGE = 16'h0001;
   localparam logic [15:0] RANGE_CURRENT = 16'h0006;
   localparam logic [15:0] CTRL_OUTEN    = 16'h1000;

   // readback status bits
   localparam int STAT_CRC       = 4;
   localparam int STAT_WATCHDOG  = 3;
   localparam int STAT_LOAD      = 2;
   localparam int STAT_SLEW      = 1;
   localparam int STAT_OVER_TEMP = 0;

   localparam int         CAPTURE_BIT    = 24;
   localparam logic [4:0] FRAME_MSB      = 5'd23;
   localparam int         MAX_CMD_FRAMES = 4;

   // capture flag, address byte, data word
   typedef logic [24:0] frame_type;

   typedef struct packed {
      logic [2:0]                          count;
      frame_type [MAX_CMD_FRAMES-1:0]      frames;
   } cmd_frames_type;

   typedef struct packed {
      logic           valid;
      cmd_frames_type cmd;
   } load_type;

   typedef struct packed {
      logic        mosi_bit;
      logic        clock_pulse;
      logic        latch_pulse;
      logic        read_valid;
      logic [15:0] read_word;
      logic        busy;
      logic        empty;
   } queue_status_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [23:0] setpoint;
      logic               miso_bit;
   } req_item_type;

   typedef struct packed {
      logic        mosi_bit;
      logic        clock_pulse;
      logic        latch_pulse;
      logic        busy_res;
      logic        cmd_rejected;
      logic        read_valid;
      logic [15:0] read_word;
      logic        crc_fault;
      logic        watchdog_fault;
      logic        load_fault;
      logic        slew_active;
      logic        over_temp;
   } rsp_item_type;

   function automatic frame_type make_frame(input logic [7:0] addr, input logic [15:0] data,
                                            input logic capture);
      return {capture, addr, data};
   endfunction

   // frames queued for one command, first frame at index 0
   function automatic cmd_frames_type cmd_frames(input req_code_type code,
                                                 input logic [15:0] dac_code);
      cmd_frames_type f;
      f.count  = 3'd0;
      f.frames = '0;
      case (code)
         REQ_INIT: begin
            f.count     = 3'd3;
            f.frames[0] = make_frame(ADDR_CONFIG, DATA_ZERO, 1'b0);
            f.frames[1] = make_frame(ADDR_CONTROL, RANGE_VOLTAGE, 1'b0);
            f.frames[2] = make_frame(ADDR_DATA, DATA_ZERO, 1'b0);
         end
         REQ_DISABLE: begin
            f.count     = 3'd1;
            f.frames[0] = make_frame(ADDR_CONTROL, RANGE_VOLTAGE, 1'b0);
         end
         REQ_CURRENT: begin
            f.count     = 3'd2;
            f.frames[0] = make_frame(ADDR_CONTROL, CTRL_OUTEN | RANGE_CURRENT, 1'b0);
            f.frames[1] = make_frame(ADDR_DATA, dac_code, 1'b0);
         end
         REQ_VOLTAGE: begin
            f.count     = 3'd2;
            f.frames[0] = make_frame(ADDR_CONTROL, CTRL_OUTEN | RANGE_VOLTAGE, 1'b0);
            f.frames[1] = make_frame(ADDR_DATA, dac_code, 1'b0);
         end
         REQ_STATUS: begin
            f.count     = 3'd2;
            f.frames[0] = make_frame(ADDR_READ, DATA_ZERO, 1'b0);
            f.frames[1] = make_frame(ADDR_NOP, DATA_ZERO, 1'b1);
         end
         REQ_RESET: begin
            f.count     = 3'd4;
            f.frames[0] = make_frame(ADDR_RESET, RESET_KEY, 1'b0);
            f.frames[1] = make_frame(ADDR_CONFIG, DATA_ZERO, 1'b0);
            f.frames[2] = make_frame(ADDR_CONTROL, RANGE_VOLTAGE, 1'b0);
            f.frames[3] = make_frame(ADDR_DATA, DATA_ZERO, 1'b0);
         end
         default: begin
            f.count = 3'd0;
         end
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

[sv/dsc_chan_if.sv]
// ----------------------------------------------------------------------------
// dsc_chan_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
`default_nettype none

interface dsc_chan_if #(parameter type item_type = logic) ();
   logic     valid;
   logic     ready;
   item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

[sv/dsc_scale.sv]
// ----------------------------------------------------------------------------
// dsc_scale
// clamps a signed q8.16 setpoint to full scale and converts it to a 16-bit
// dac code, rounded half up
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_scale
   import dsc_pkg::*;
(
   input  logic signed [23:0] setpoint,
   input  logic               is_current,
   output logic [15:0]        dac_code
);

   localparam int         FS_CURRENT  = 20;
   localparam int         FS_VOLTAGE  = 10;
   localparam logic [20:0] DEN_CURRENT = 21'(FS_CURRENT * 65536);
   localparam logic [20:0] DEN_VOLTAGE = 21'(FS_VOLTAGE * 65536);
   // floor(2^24 / 5)
   localparam logic [21:0] RECIP5      = 22'((1 << 24) / 5);

   logic [20:0] den;
   logic [20:0] clamped;
   logic [37:0] numer;
   logic [20:0] scaled;
   logic [18:0] quot_in;
   logic [40:0] prod;
   logic [16:0] q_est;
   logic [18:0] rem;
   logic [16:0] q_fix;

   always_comb begin
      den = is_current ? DEN_CURRENT : DEN_VOLTAGE;
      if (setpoint[23]) begin
         clamped = '0;
      end else if (setpoint[22:0] > 23'(den)) begin
         clamped = den;
      end else begin
         clamped = setpoint[20:0];
      end
      // s * 65535 * 2 + den, then divide by 2^17 and by full scale
      numer   = (38'(clamped) << 17) - (38'(clamped) << 1) + 38'(den);
      scaled  = numer[37:17];
      quot_in = is_current ? 19'(scaled >> 2) : 19'(scaled >> 1);
      prod    = 41'(quot_in) * 41'(RECIP5);
      q_est   = prod[40:24];
      rem     = quot_in - (19'({q_est, 2'b00}) + 19'(q_est));
      q_fix   = (rem >= 19'd5) ? q_est + 17'd1 : q_est;
      dac_code = (q_fix > 17'h0FFFF) ? 16'hFFFF : q_fix[15:0];
   end

endmodule

`default_nettype wire

[sv/dsc_frame_queue.sv]
// ----------------------------------------------------------------------------
// dsc_frame_queue
// frame queue with head shifter: one bit per tick, latch after bit 0,
// miso capture for status frames
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_frame_queue
   import dsc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic             clock,
   input  logic             reset,
   input  load_type         load,
   input  logic             tick,
   input  logic             miso_bit,
   output queue_status_type status
);

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int LOAD_N = (QUEUE_DEPTH < MAX_CMD_FRAMES) ? QUEUE_DEPTH : MAX_CMD_FRAMES;

   frame_type        queue_ff [QUEUE_DEPTH];
   frame_type        queue_in [QUEUE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [4:0]       bit_index_ff, bit_index_in;
   logic [15:0]      miso_shift_ff, miso_shift_in;

   frame_type head;
   logic [4:0] bsel;
   logic       shifting;
   logic       last;

   always_comb begin
      head     = queue_ff[0];
      bsel     = (bit_index_ff > FRAME_MSB) ? FRAME_MSB : bit_index_ff;
      shifting = tick && (count_ff != '0);
      last     = shifting && (bsel == 5'd0);

      queue_in      = queue_ff;
      count_in      = count_ff;
      bit_index_in  = bit_index_ff;
      miso_shift_in = miso_shift_ff;

      if (shifting) begin
         miso_shift_in = {miso_shift_ff[14:0], head[CAPTURE_BIT] & miso_bit};
         bit_index_in  = last ? FRAME_MSB : bsel - 5'd1;
      end

      // loads only happen with an empty queue, so never together with a pop
      if (load.valid) begin
         for (int i = 0; i < LOAD_N; i++) begin
            queue_in[i] = load.cmd.frames[i];
         end
         count_in = CNT_W'(load.cmd.count);
      end else if (last) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
         count_in = count_ff - CNT_W'(1);
      end

      status.mosi_bit    = shifting & head[bsel];
      status.clock_pulse = shifting;
      status.latch_pulse = last;
      status.read_valid  = last & head[CAPTURE_BIT];
      status.read_word   = status.read_valid ? miso_shift_in : 16'h0000;
      status.busy        = (count_in != '0);
      status.empty       = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         bit_index_ff  <= FRAME_MSB;
         miso_shift_ff <= '0;
      end else begin
         count_ff      <= count_in;
         bit_index_ff  <= bit_index_in;
         miso_shift_ff <= miso_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

endmodule

`default_nettype wire

[sv/dac_spi_command_sequencer.sv]
// ----------------------------------------------------------------------------
// dac_spi_command_sequencer
// command-level sequencer for a 24-bit spi mode-0 dac
// ----------------------------------------------------------------------------
// Every req item gives exactly one rsp item, through an input register and
// then a result register, and a new item is taken every clock while rsp is
// ready. A command item (init, disable, set current, set voltage, read status,
// reset) loads its frames into the queue when the queue is empty and is
// otherwise rejected; a tick item shifts one bit of the head frame out on
// mosi_bit, msb first, samples miso_bit and pulses latch after bit 0. A status
// read returns the 16 bits captured during its nop frame with the flags
// decoded. The longest path is the setpoint-to-code conversion: one 19x22
// multiply by a reciprocal plus a compare-and-correct.
`default_nettype none

module dac_spi_command_sequencer
   import dsc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   dsc_chan_if.sink   req,
   dsc_chan_if.source rsp
);

   req_item_type item_ff, item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         out_valid_ff, out_valid_in;

   logic             advance;
   logic             take;
   req_code_type     code;
   logic             is_cmd;
   logic             tick;
   logic [15:0]      dac_code;
   load_type         load;
   queue_status_type qstat;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign take      = req.valid && req.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.item  = rsp_ff;

   always_comb begin
      code = req_code_type'(item_ff.req_type);
      case (code)
         REQ_INIT, REQ_DISABLE, REQ_CURRENT, REQ_VOLTAGE, REQ_STATUS, REQ_RESET: begin
            is_cmd = 1'b1;
         end
         default: begin
            is_cmd = 1'b0;
         end
      endcase
      tick       = advance && (code == REQ_TICK);
      load.valid = advance && is_cmd && qstat.empty;
      load.cmd   = cmd_frames(code, dac_code);
   end

   dsc_scale u_scale (
      .setpoint   (item_ff.setpoint),
      .is_current (code == REQ_CURRENT),
      .dac_code   (dac_code)
   );

   dsc_frame_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .tick     (tick),
      .miso_bit (item_ff.miso_bit),
      .status   (qstat)
   );

   always_comb begin
      item_in     = take ? req.item : item_ff;
      in_valid_in = take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp.ready);

      rsp_in = rsp_ff;
      if (advance) begin
         rsp_in.mosi_bit       = qstat.mosi_bit;
         rsp_in.clock_pulse    = qstat.clock_pulse;
         rsp_in.latch_pulse    = qstat.latch_pulse;
         rsp_in.busy_res       = qstat.busy;
         rsp_in.cmd_rejected   = is_cmd && !qstat.empty;
         rsp_in.read_valid     = qstat.read_valid;
         rsp_in.read_word      = qstat.read_word;
         rsp_in.crc_fault      = qstat.read_word[STAT_CRC];
         rsp_in.watchdog_fault = qstat.read_word[STAT_WATCHDOG];
         rsp_in.load_fault     = qstat.read_word[STAT_LOAD];
         rsp_in.slew_active    = qstat.read_word[STAT_SLEW];
         rsp_in.over_temp      = qstat.read_word[STAT_OVER_TEMP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

[sv/dsc_checker.sv]
// ----------------------------------------------------------------------------
// dsc_checker
// port-level checks on the sequencer result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "dac_spi_command_sequencer_defines.svh"
`default_nettype none

module dsc_checker
   import dsc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   logic [4:0] flag_bits;
   logic       word_ok;
   logic       reject_ok;

   assign flag_bits = {rsp_item.crc_fault, rsp_item.watchdog_fault, rsp_item.load_fault,
                       rsp_item.slew_active, rsp_item.over_temp};
   assign word_ok   = rsp_item.read_valid || (rsp_item.read_word == 16'h0000);
   assign reject_ok = rsp_item.busy_res && !rsp_item.clock_pulse;

   `DSC_ASSERT_NOW(a_latch_needs_clock, rsp_valid && rsp_item.latch_pulse, rsp_item.clock_pulse)
   `DSC_ASSERT_NOW(a_read_on_latch, rsp_valid && rsp_item.read_valid, rsp_item.latch_pulse)
   `DSC_ASSERT_NOW(a_reject_no_shift, rsp_valid && rsp_item.cmd_rejected, reject_ok)
   `DSC_ASSERT_NOW(a_flags_match, rsp_valid, word_ok && (flag_bits == rsp_item.read_word[4:0]))
   `DSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

endmodule

bind dac_spi_command_sequencer dsc_checker u_dsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_item  (rsp.item)
);

`default_nettype wire

[tb/sv/dac_spi_command_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// dac_spi_command_sequencer_tb
// drives command and tick items into the spi dac sequencer and checks every
// result item against a cycle-free model of the frame queue, the bit shifter,
// the setpoint scaling and the status capture; directed cases first, then
// random command sequences with random miso data, bursty sender, stalling sink
// ----------------------------------------------------------------------------
`default_nettype none

module dac_spi_command_sequencer_tb
   import dsc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          QUEUE_DEPTH  = 4;
   localparam int unsigned FS_CURRENT   = 20;
   localparam int unsigned FS_VOLTAGE   = 10;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned SETTLE_WAIT  = 8;
   localparam int          MISO_ZERO    = 0;
   localparam int          MISO_ONE     = 1;
   localparam int          MISO_RANDOM  = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dsc_chan_if #(.item_type(req_item_type)) req_if ();
   dsc_chan_if #(.item_type(rsp_item_type)) rsp_if ();

   dac_spi_command_sequencer #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // model state
   frame_type      dac_frames[$];
   logic [4:0]     shift_bit;
   logic [15:0]    miso_capture;
   rsp_item_type   spi_rsp_due[$];
   int unsigned    mismatch_count = 0;
   int unsigned    burst_left = 0;
   int unsigned    cycle_count = 0;

   logic [15:0]    stall_lfsr = 16'hACE1;
   int unsigned    stall_phase = 0;
   int unsigned    stall_mode = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // sink stall pattern: stretches of none, light and heavy stalling
   always @(posedge clock) begin
      stall_lfsr <= {stall_lfsr[14:0],
                     stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
      if (stall_phase == 0) begin
         stall_phase <= $urandom_range(20, 200);
         stall_mode  <= $urandom_range(0, 2);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= stall_lfsr[0] | stall_lfsr[5];
         default: rsp_if.ready <= stall_lfsr[0] & stall_lfsr[2];
      endcase
   end

   function automatic logic [15:0] dac_code_of(input logic [23:0] sp, input int unsigned fs);
      logic [63:0] s;
      logic [63:0] den;
      logic [63:0] q;
      den = 64'(fs) * 64'd65536;
      s   = sp[23] ? 64'd0 : {40'd0, sp};
      if (s > den) s = den;
      q = (s * 64'd131070 + den) / (den * 64'd2);
      return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic void queue_frame(input logic [7:0] addr, input logic [15:0] data,
                                       input logic capture);
      if (dac_frames.size() < QUEUE_DEPTH) dac_frames.push_back({capture, addr, data});
   endfunction

   function automatic void queue_init_frames();
      queue_frame(ADDR_CONFIG, DATA_ZERO, 1'b0);
      queue_frame(ADDR_CONTROL, RANGE_VOLTAGE, 1'b0);
      queue_frame(ADDR_DATA, DATA_ZERO, 1'b0);
   endfunction

   function automatic rsp_item_type spi_predict(input req_item_type it);
      rsp_item_type r;
      req_code_type code;
      frame_type    head;
      logic         cap;
      logic [4:0]   b;
      r    = '0;
      code = req_code_type'(it.req_type);
      if (code != REQ_TICK && code != REQ_NOP) begin
         if (dac_frames.size() != 0) begin
            r.cmd_rejected = 1'b1;
         end else begin
            case (code)
               REQ_INIT: queue_init_frames();
               REQ_DISABLE: queue_frame(ADDR_CONTROL, RANGE_VOLTAGE, 1'b0);
               REQ_CURRENT: begin
                  queue_frame(ADDR_CONTROL, CTRL_OUTEN | RANGE_CURRENT, 1'b0);
                  queue_frame(ADDR_DATA, dac_code_of(it.setpoint, FS_CURRENT), 1'b0);
               end
               REQ_VOLTAGE: begin
                  queue_frame(ADDR_CONTROL, CTRL_OUTEN | RANGE_VOLTAGE, 1'b0);
                  queue_frame(ADDR_DATA, dac_code_of(it.setpoint, FS_VOLTAGE), 1'b0);
               end
               REQ_STATUS: begin
                  queue_frame(ADDR_READ, DATA_ZERO, 1'b0);
                  queue_frame(ADDR_NOP, DATA_ZERO, 1'b1);
               end
               default: begin
                  queue_frame(ADDR_RESET, RESET_KEY, 1'b0);
                  queue_init_frames();
               end
            endcase
         end
      end else if (code == REQ_TICK && dac_frames.size() != 0) begin
         head          = dac_frames[0];
         cap           = head[CAPTURE_BIT];
         b             = (shift_bit > FRAME_MSB) ? FRAME_MSB : shift_bit;
         r.mosi_bit    = head[b];
         r.clock_pulse = 1'b1;
         miso_capture  = {miso_capture[14:0], cap & it.miso_bit};
         if (b == 5'd0) begin
            r.latch_pulse = 1'b1;
            if (cap) begin
               r.read_valid     = 1'b1;
               r.read_word      = miso_capture;
               r.crc_fault      = miso_capture[STAT_CRC];
               r.watchdog_fault = miso_capture[STAT_WATCHDOG];
               r.load_fault     = miso_capture[STAT_LOAD];
               r.slew_active    = miso_capture[STAT_SLEW];
               r.over_temp      = miso_capture[STAT_OVER_TEMP];
            end
            void'(dac_frames.pop_front());
            shift_bit = FRAME_MSB;
         end else begin
            shift_bit = b - 5'd1;
         end
      end
      r.busy_res = (dac_frames.size() != 0);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0h, actual %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.item;
         if (spi_rsp_due.size() == 0) begin
            mismatch_count++;
            $error("result item with nothing outstanding");
         end else begin
            want = spi_rsp_due.pop_front();
            check_field("mosi_bit", 16'(want.mosi_bit), 16'(got.mosi_bit));
            check_field("clock_pulse", 16'(want.clock_pulse), 16'(got.clock_pulse));
            check_field("latch_pulse", 16'(want.latch_pulse), 16'(got.latch_pulse));
            check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
            check_field("cmd_rejected", 16'(want.cmd_rejected), 16'(got.cmd_rejected));
            check_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
            check_field("read_word", want.read_word, got.read_word);
            check_field("crc_fault", 16'(want.crc_fault), 16'(got.crc_fault));
            check_field("watchdog_fault", 16'(want.watchdog_fault), 16'(got.watchdog_fault));
            check_field("load_fault", 16'(want.load_fault), 16'(got.load_fault));
            check_field("slew_active", 16'(want.slew_active), 16'(got.slew_active));
            check_field("over_temp", 16'(want.over_temp), 16'(got.over_temp));
         end
      end
   end

   function automatic req_item_type make_req(input req_code_type code, input logic [23:0] sp,
                                             input logic miso);
      req_item_type it;
      it.req_type = code;
      it.setpoint = sp;
      it.miso_bit = miso;
      return it;
   endfunction

   // bursts of random length, random gaps between them
   task automatic send_item(input req_item_type it);
      req_if.valid <= 1'b1;
      req_if.item  <= it;
      do @(posedge clock); while (!req_if.ready);
      spi_rsp_due.push_back(spi_predict(it));
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_frames(input int miso_mode);
      logic m;
      while (dac_frames.size() != 0) begin
         m = (miso_mode == MISO_RANDOM) ? 1'($urandom_range(0, 1)) : (miso_mode == MISO_ONE);
         send_item(make_req(REQ_TICK, 24'($urandom()), m));
      end
   endtask

   function automatic logic [23:0] rand_setpoint(input req_code_type code);
      int unsigned fs;
      fs = (code == REQ_VOLTAGE) ? FS_VOLTAGE : FS_CURRENT;
      case ($urandom_range(0, 5))
         0: return 24'($urandom());
         1, 2, 3: return 24'($urandom_range(0, fs * 65536));
         4: return 24'(fs * 65536 + $urandom_range(0, 4) - 2);
         default: return 24'($urandom_range(24'h800000, 24'hFFFFFF));
      endcase
   endfunction

   task automatic test_idle_inputs();
      send_item(make_req(REQ_TICK, 24'h000000, 1'b0));
      send_item(make_req(REQ_TICK, 24'hFFFFFF, 1'b1));
      send_item(make_req(REQ_NOP, 24'h7FFFFF, 1'b1));
      send_item(make_req(REQ_NOP, 24'h800000, 1'b0));
   endtask

   task automatic test_init();
      send_item(make_req(REQ_INIT, 24'h000000, 1'b0));
      drain_frames(MISO_ONE);
   endtask

   task automatic test_disable();
      send_item(make_req(REQ_DISABLE, 24'h000000, 1'b0));
      drain_frames(MISO_RANDOM);
   endtask

   task automatic test_set_current();
      logic [23:0] sp[4];
      sp = '{24'h800000, 24'h000000, 24'h140000, 24'h7FFFFF};
      foreach (sp[i]) begin
         send_item(make_req(REQ_CURRENT, sp[i], 1'b0));
         drain_frames(MISO_RANDOM);
      end
   endtask

   task automatic test_set_voltage();
      logic [23:0] sp[4];
      sp = '{24'hFFFFFF, 24'h000001, 24'h0A0000, 24'h050000};
      foreach (sp[i]) begin
         send_item(make_req(REQ_VOLTAGE, sp[i], 1'b1));
         drain_frames(MISO_RANDOM);
      end
   endtask

   task automatic test_status_read();
      send_item(make_req(REQ_STATUS, 24'h000000, 1'b0));
      drain_frames(MISO_ONE);
      send_item(make_req(REQ_STATUS, 24'h000000, 1'b1));
      drain_frames(MISO_ZERO);
      send_item(make_req(REQ_STATUS, 24'h000000, 1'b0));
      drain_frames(MISO_RANDOM);
   endtask

   task automatic test_soft_reset();
      send_item(make_req(REQ_RESET, 24'h000000, 1'b0));
      drain_frames(MISO_RANDOM);
   endtask

   // every command while frames are pending is dropped
   task automatic test_busy_reject();
      send_item(make_req(REQ_INIT, 24'h000000, 1'b0));
      send_item(make_req(REQ_TICK, 24'h000000, 1'b1));
      for (int c = REQ_INIT; c <= REQ_RESET; c++)
         send_item(make_req(req_code_type'(c), 24'($urandom()), 1'b1));
      send_item(make_req(REQ_NOP, 24'h000000, 1'b1));
      send_item(make_req(REQ_TICK, 24'h000000, 1'b0));
      drain_frames(MISO_RANDOM);
   endtask

   // well-formed command sequences with random miso, some rejects and noise
   task automatic test_random_traffic();
      int unsigned  counted;
      int unsigned  pick;
      req_code_type code;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (dac_frames.size() == 0) begin
            if (pick < 80) code = req_code_type'($urandom_range(REQ_INIT, REQ_RESET));
            else if (pick < 90) code = REQ_TICK;
            else code = REQ_NOP;
         end else begin
            if (pick < 93) code = REQ_TICK;
            else if (pick < 97) code = req_code_type'($urandom_range(REQ_INIT, REQ_RESET));
            else code = REQ_NOP;
         end
         if (code != REQ_NOP && (code != REQ_TICK || dac_frames.size() != 0)) counted++;
         send_item(make_req(code, rand_setpoint(code), 1'($urandom_range(0, 1))));
      end
      req_if.valid <= 1'b0;
   endtask

   initial begin
      req_if.valid  = 1'b0;
      req_if.item   = '0;
      shift_bit     = FRAME_MSB;
      miso_capture  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_inputs();
      test_init();
      test_disable();
      test_set_current();
      test_set_voltage();
      test_status_read();
      test_soft_reset();
      test_busy_reject();
      test_random_traffic();
      while (spi_rsp_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

[dac_spi_command_sequencer.f]
+incdir+sv
sv/dsc_pkg.sv
sv/dsc_chan_if.sv
sv/dsc_scale.sv
sv/dsc_frame_queue.sv
sv/dac_spi_command_sequencer.sv
sv/dsc_checker.sv
tb/sv/dac_spi_command_sequencer_tb.sv
